// ===== src/fisync_pkg.sv =====
// ----------------------------------------------------------------------------
// fisync_pkg
// Types and codes shared by the frame id pair synchronizer modules.
// ----------------------------------------------------------------------------
package fisync_pkg;

  localparam logic [1:0] OP_CLOUD  = 2'd0;
  localparam logic [1:0] OP_ODOM   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REG_SYNC    = 2'd0;
  localparam logic [1:0] REG_MAX_LAG = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic EV_CLOUD = 1'b0;
  localparam logic EV_ODOM  = 1'b1;

  localparam logic [4:0]  MAX_LAG_RESET = 5'd8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    CMD_CLOUD,
    CMD_ODO,
    CMD_PASS,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRIM,
    ST_PAIR
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  fid;
    logic [63:0] timestamp;
    logic [1:0]  odom_source;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic clr;
    logic pop;
    logic rm;
    logic push;
  } q_ctl_t;

  typedef struct packed {
    logic        reject;
    logic        trim;
    logic        hit;
    logic [7:0]  hit_id;
    logic [63:0] hit_ts;
    logic [31:0] hit_pay;
  } q_stat_t;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  fid;
    logic [63:0] timestamp;
    logic [31:0] payload;
    logic [1:0]  odom_source;
    logic [31:0] odom_payload;
    logic        mismatch;
    logic        last;
  } res_t;

endpackage

// ===== src/fisync_front.sv =====
// ----------------------------------------------------------------------------
// fisync_front
// Accepts input beats, classifies them into commands and queues them; beats with the unused opcode are dropped.
// ----------------------------------------------------------------------------
module fisync_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [7:0]           fid,
  input  logic [63:0]          timestamp,
  input  logic [1:0]           odom_source,
  input  logic [31:0]          payload,
  input  logic                 sync_en,
  output logic                 cmd_valid,
  output fisync_pkg::cmd_t     cmd,
  input  logic                 cmd_pop
);
  import fisync_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd_in;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_comb begin
    cmd_in.fid         = fid;
    cmd_in.timestamp   = timestamp;
    cmd_in.odom_source = odom_source;
    cmd_in.payload     = payload;
    cmd_in.kind        = CMD_CLEAR;
    push               = in_valid && in_ready;
    case (opcode)
      OP_CLOUD: cmd_in.kind = sync_en ? CMD_CLOUD : CMD_PASS;
      OP_ODOM:  cmd_in.kind = CMD_ODO;
      OP_CLEAR: cmd_in.kind = CMD_CLEAR;
      default:  push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

endmodule

// ===== src/fisync_queue.sv =====
// ----------------------------------------------------------------------------
// fisync_queue
// Ordered frame queue with parallel stamp and id compare and compaction.
// ----------------------------------------------------------------------------
module fisync_queue #(
  parameter int DEPTH = 16,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  fisync_pkg::q_ctl_t  ctl,
  input  logic [7:0]          probe_id,
  input  logic [63:0]         probe_ts,
  input  logic [31:0]         push_pay,
  input  logic [31:0]         timeout,
  input  logic [FW-1:0]       lim,
  output fisync_pkg::q_stat_t stat
);
  import fisync_pkg::*;

  logic [7:0]    ids    [DEPTH];
  logic [63:0]   stamps [DEPTH];
  logic [31:0]   pays   [DEPTH];
  logic [FW-1:0] fill;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] rm_idx;
  logic [63:0]   age;
  logic          expired;

  always_comb begin
    stat.reject = 1'b0;
    stat.hit    = 1'b0;
    hit_idx     = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (FW'(i) < fill) begin
        if (probe_ts <= stamps[i]) stat.reject = 1'b1;
        if (ids[i] == probe_id) begin
          stat.hit = 1'b1;
          hit_idx  = IW'(i);
        end
      end
    end
    stat.hit_id  = ids[hit_idx];
    stat.hit_ts  = stamps[hit_idx];
    stat.hit_pay = pays[hit_idx];
    age          = probe_ts - stamps[0];
    expired      = (probe_ts > stamps[0]) && (age > {32'd0, timeout});
    stat.trim    = (fill != '0) && (expired || fill >= lim);
    rm_idx       = ctl.pop ? '0 : hit_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.clr) begin
      fill <= '0;
    end else if (ctl.pop || ctl.rm) begin
      fill <= fill - FW'(1);
    end else if (ctl.push) begin
      fill <= fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop || ctl.rm) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IW'(i) >= rm_idx) begin
          ids[i]    <= ids[i + 1];
          stamps[i] <= stamps[i + 1];
          pays[i]   <= pays[i + 1];
        end
      end
    end else if (ctl.push) begin
      ids[fill[IW-1:0]]    <= probe_id;
      stamps[fill[IW-1:0]] <= probe_ts;
      pays[fill[IW-1:0]]   <= push_pay;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH)) else $error("queue fill above depth");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push && !ctl.clr |-> fill < lim) else $error("push beyond lag limit");
  a_rm_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.rm |-> stat.hit) else $error("remove without matching entry");
`endif

endmodule

// ===== src/fisync_back.sv =====
// ----------------------------------------------------------------------------
// fisync_back
// Executes commands on the two frame queues and drives the result register.
// ----------------------------------------------------------------------------
module fisync_back #(
  parameter int DEPTH = 16,
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  fisync_pkg::cmd_t     cmd,
  output logic                 cmd_pop,
  input  logic                 sync_en,
  input  logic                 cfg_clear,
  input  logic [31:0]          timeout,
  input  logic [FW-1:0]        lim,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fisync_pkg::res_t     res
);
  import fisync_pkg::*;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  q_ctl_t      c_ctl;
  q_ctl_t      o_ctl;
  q_stat_t     c_st;
  q_stat_t     o_st;
  logic        slot_free;
  logic        load_res;
  logic        own_cloud;
  res_t        res_next;

  fisync_queue #(.DEPTH(DEPTH)) u_cloud (
    .clk(clk), .rst(rst), .ctl(c_ctl), .probe_id(cur.fid),
    .probe_ts(cur.timestamp), .push_pay(cur.payload),
    .timeout(timeout), .lim(lim), .stat(c_st)
  );

  fisync_queue #(.DEPTH(DEPTH)) u_odom (
    .clk(clk), .rst(rst), .ctl(o_ctl), .probe_id(cur.fid),
    .probe_ts(cur.timestamp), .push_pay(cur.payload),
    .timeout(timeout), .lim(lim), .stat(o_st)
  );

  assign slot_free = !out_valid || out_ready;
  assign own_cloud = (cur.kind == CMD_CLOUD);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    c_ctl      = '0;
    o_ctl      = '0;
    c_ctl.clr  = cfg_clear;
    o_ctl.clr  = cfg_clear;
    load_res   = 1'b0;
    res_next   = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cur.kind)
          CMD_CLEAR: begin
            c_ctl.clr  = 1'b1;
            o_ctl.clr  = 1'b1;
            state_next = ST_IDLE;
          end
          CMD_PASS: begin
            if (slot_free) begin
              load_res             = 1'b1;
              res_next.event_kind  = EV_CLOUD;
              res_next.fid         = cur.fid;
              res_next.timestamp   = cur.timestamp;
              res_next.payload     = cur.payload;
              res_next.last        = 1'b1;
              state_next           = ST_IDLE;
            end
          end
          CMD_CLOUD: state_next = c_st.reject ? ST_IDLE : ST_TRIM;
          CMD_ODO: begin
            if (slot_free) begin
              load_res             = 1'b1;
              res_next.event_kind  = EV_ODOM;
              res_next.fid         = cur.fid;
              res_next.timestamp   = cur.timestamp;
              res_next.payload     = cur.payload;
              res_next.odom_source = cur.odom_source;
              res_next.last        = !(sync_en && !o_st.reject && c_st.hit);
              state_next = (!sync_en || o_st.reject) ? ST_IDLE : ST_TRIM;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_TRIM: begin
        if (own_cloud) begin
          if (c_st.trim) c_ctl.pop = 1'b1;
          else state_next = ST_PAIR;
        end else begin
          if (o_st.trim) o_ctl.pop = 1'b1;
          else state_next = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (own_cloud) begin
          if (o_st.hit) begin
            if (slot_free) begin
              load_res              = 1'b1;
              res_next.event_kind   = EV_CLOUD;
              res_next.fid          = cur.fid;
              res_next.timestamp    = cur.timestamp;
              res_next.payload      = cur.payload;
              res_next.odom_payload = o_st.hit_pay;
              res_next.mismatch     = (cur.timestamp != o_st.hit_ts);
              res_next.last         = 1'b1;
              o_ctl.rm              = 1'b1;
              state_next            = ST_IDLE;
            end
          end else begin
            c_ctl.push = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          if (c_st.hit) begin
            if (slot_free) begin
              load_res              = 1'b1;
              res_next.event_kind   = EV_CLOUD;
              res_next.fid          = c_st.hit_id;
              res_next.timestamp    = c_st.hit_ts;
              res_next.payload      = c_st.hit_pay;
              res_next.odom_payload = cur.payload;
              res_next.mismatch     = (c_st.hit_ts != cur.timestamp);
              res_next.last         = 1'b1;
              c_ctl.rm              = 1'b1;
              state_next            = ST_IDLE;
            end
          end else begin
            o_ctl.push = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur <= cmd;
    if (load_res) res <= res_next;
  end

endmodule

// ===== src/frame_id_pair_synchronizer.sv =====
// Pass-through and odometry beats go through the command buffer and the IDLE
// and EXEC states of the command sequencer into the result register; a pairing
// result also passes TRIM, which pops expired or lagging entries from the head
// of its queue one at a time, and then PAIR. The sequencer handles one command
// at a time while the front buffer takes further beats until it is full; a waiting output beat stalls the sequencer.
// Reset empties both queues and loads the register defaults.
// ----------------------------------------------------------------------------
// frame_id_pair_synchronizer
// Pairs point-cloud and odometry frames by frame id, with timeout and lag.
// ----------------------------------------------------------------------------
module frame_id_pair_synchronizer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  fid,
  input  logic [63:0] timestamp,
  input  logic [1:0]  odom_source,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_kind,
  output logic [7:0]  frame_id_out,
  output logic [63:0] timestamp_out,
  output logic [31:0] payload_out,
  output logic [1:0]  odom_source_out,
  output logic [31:0] paired_odom_payload,
  output logic        stamp_mismatch,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fisync_pkg::*;

  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  logic          sync_en;
  logic [4:0]    max_lag;
  logic [31:0]   timeout;
  logic [FW-1:0] lim;
  logic          cfg_clear;
  logic          cmd_valid;
  logic          cmd_pop;
  cmd_t          cmd;
  res_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_en <= 1'b1;
      max_lag <= MAX_LAG_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC:    sync_en <= cfg_data[0];
        REG_MAX_LAG: max_lag <= cfg_data[4:0];
        REG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we && (cfg_index == REG_SYNC) && !cfg_data[0];

  always_comb begin
    if (max_lag == 5'd0) lim = FW'(1);
    else if (32'(max_lag) > QUEUE_DEPTH) lim = FW'(QUEUE_DEPTH);
    else lim = FW'(max_lag);
  end

  fisync_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .fid(fid), .timestamp(timestamp),
    .odom_source(odom_source), .payload(payload), .sync_en(sync_en),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  fisync_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .sync_en(sync_en), .cfg_clear(cfg_clear), .timeout(timeout), .lim(lim),
    .out_valid(out_valid), .out_ready(out_ready), .res(res)
  );

  assign event_kind          = res.event_kind;
  assign frame_id_out        = res.fid;
  assign timestamp_out       = res.timestamp;
  assign payload_out         = res.payload;
  assign odom_source_out     = res.odom_source;
  assign paired_odom_payload = res.odom_payload;
  assign stamp_mismatch      = res.mismatch;
  assign last                = res.last;

endmodule

// ===== tb/frame_id_pair_synchronizer_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_id_pair_synchronizer_chk
// Watches the input, output and register ports of the synchronizer, keeps a
// model of both frame queues, and compares every output beat in order.
// ----------------------------------------------------------------------------
module frame_id_pair_synchronizer_chk #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  fid,
  input  logic [63:0] timestamp,
  input  logic [1:0]  odom_source,
  input  logic [31:0] payload,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        event_kind,
  input  logic [7:0]  frame_id_out,
  input  logic [63:0] timestamp_out,
  input  logic [31:0] payload_out,
  input  logic [1:0]  odom_source_out,
  input  logic [31:0] paired_odom_payload,
  input  logic        stamp_mismatch,
  input  logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import fisync_pkg::*;

  typedef struct {
    logic [7:0]  id;
    logic [63:0] ts;
    logic [31:0] pay;
  } frame_t;

  frame_t      clouds[$];
  frame_t      odos[$];
  res_t        want[$];
  logic        sync_on;
  logic [4:0]  lag;
  logic [31:0] tmo;

  function automatic int lag_cap();
    int m;
    m = int'(lag);
    if (m < 1) m = 1;
    if (m > QUEUE_DEPTH) m = QUEUE_DEPTH;
    return m;
  endfunction

  function automatic logic stale(logic [63:0] now, logic [63:0] old);
    return (now > old) && ((now - old) > {32'd0, tmo});
  endfunction

  // returns 0 if rejected
  function automatic bit enqueue(ref frame_t q[$], input frame_t f);
    int i;
    foreach (q[k]) if (f.ts <= q[k].ts) return 0;
    i = 0;
    while (i < q.size()) begin
      if (stale(f.ts, q[i].ts)) q.delete(i);
      else i++;
    end
    while (q.size() >= lag_cap()) q.delete(0);
    q.insert(q.size(), f);
    return 1;
  endfunction

  function automatic void pair_up();
    res_t r;
    foreach (clouds[c]) begin
      foreach (odos[d]) begin
        if (clouds[c].id == odos[d].id) begin
          r = '0;
          r.event_kind   = EV_CLOUD;
          r.fid          = clouds[c].id;
          r.timestamp    = clouds[c].ts;
          r.payload      = clouds[c].pay;
          r.odom_payload = odos[d].pay;
          r.mismatch     = clouds[c].ts != odos[d].ts;
          want.insert(want.size(), r);
          clouds.delete(c);
          odos.delete(d);
          return;
        end
      end
    end
  endfunction

  function automatic void predict_beat();
    frame_t f;
    res_t   r;
    int     n0;
    n0 = want.size();
    f.id = fid;
    f.ts = timestamp;
    f.pay = payload;
    r = '0;
    r.fid       = fid;
    r.timestamp = timestamp;
    r.payload   = payload;
    if (opcode == OP_CLEAR) begin
      clouds.delete();
      odos.delete();
    end else if (opcode == OP_CLOUD) begin
      if (!sync_on) begin
        r.event_kind = EV_CLOUD;
        want.insert(want.size(), r);
      end else if (enqueue(clouds, f)) begin
        pair_up();
      end
    end else if (opcode == OP_ODOM) begin
      r.event_kind  = EV_ODOM;
      r.odom_source = odom_source;
      want.insert(want.size(), r);
      if (sync_on && enqueue(odos, f)) pair_up();
    end
    if (want.size() > n0) want[want.size()-1].last = 1'b1;
  endfunction

  task automatic compare_beat();
    res_t e, a;
    a.event_kind   = event_kind;
    a.fid          = frame_id_out;
    a.timestamp    = timestamp_out;
    a.payload      = payload_out;
    a.odom_source  = odom_source_out;
    a.odom_payload = paired_odom_payload;
    a.mismatch     = stamp_mismatch;
    a.last         = last;
    if (want.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output beat %p", a);
    end else begin
      e = want[0];
      want.delete(0);
      if (a !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clouds.delete();
      odos.delete();
      want.delete();
      sync_on <= 1'b1;
      lag     <= MAX_LAG_RESET;
      tmo     <= TIMEOUT_RESET;
      errors  = 0;
    end else begin
      if (out_valid && out_ready) compare_beat();
      if (in_valid && in_ready) predict_beat();
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC: begin
            sync_on <= cfg_data[0];
            if (!cfg_data[0]) begin
              clouds.delete();
              odos.delete();
            end
          end
          REG_MAX_LAG: lag <= cfg_data[4:0];
          REG_TIMEOUT: tmo <= cfg_data;
          default: ;
        endcase
      end
    end
    pending = want.size();
  end

endmodule

// ===== tb/frame_id_pair_synchronizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_id_pair_synchronizer_tb
// Drives directed and random frame sequences through several register
// settings with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module frame_id_pair_synchronizer_tb;
  import fisync_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_CLEAR;
  logic [7:0]  fid = '0;
  logic [63:0] timestamp = '0;
  logic [1:0]  odom_source = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        event_kind;
  logic [7:0]  frame_id_out;
  logic [63:0] timestamp_out;
  logic [31:0] payload_out;
  logic [1:0]  odom_source_out;
  logic [31:0] paired_odom_payload;
  logic        stamp_mismatch;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_SYNC;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          calm = 0;
  bit          hold_off = 0;
  logic [63:0] ts_base;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frame_id_pair_synchronizer DUT (.*);
  frame_id_pair_synchronizer_chk CHK (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      if (!calm && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(negedge clk);
      end
    end
  end

  // valid stays high after the beat until the next idle gap or register write
  task automatic send(logic [1:0] op, logic [7:0] id, logic [63:0] ts,
                      logic [1:0] src, logic [31:0] pay);
    int n;
    if (!calm && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 5);
      repeat (n) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    fid         <= id;
    timestamp   <= ts;
    odom_source <= src;
    payload     <= pay;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed stream: pairs with rising stamps, some jitter and noise
  task automatic random_run(int count, int id_span);
    logic [63:0] step;
    logic [7:0]  id;
    int          r;
    for (int i = 0; i < count; i++) begin
      step = 64'($urandom_range(1, 400000));
      if ($urandom_range(30) == 0) step = 64'd3000000 + 64'($urandom);
      ts_base += step;
      id = 8'($urandom_range(id_span));
      r = $urandom_range(99);
      if (r < 42) send(OP_CLOUD, id, ts_base, 2'($urandom), $urandom);
      else if (r < 84) send(OP_ODOM, id, ts_base + 64'($urandom_range(3) == 0),
                            2'($urandom), $urandom);
      else if (r < 92) send(2'($urandom_range(1)), 8'($urandom),
                            ts_base - 64'($urandom_range(500000)),
                            2'($urandom), $urandom);
      else if (r < 95) send(OP_CLEAR, 8'($urandom), 64'($urandom), 2'($urandom),
                            $urandom);
      else if (r < 97) send(OP_UNUSED, 8'($urandom), 64'($urandom), 2'($urandom),
                            $urandom);
      else send(2'($urandom_range(1)), 8'($urandom), {$urandom, $urandom},
                2'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    send(OP_CLOUD, 8'h00, 64'd10, 2'd0, 32'h0);
    send(OP_ODOM, 8'h00, 64'd10, 2'd3, 32'hFFFFFFFF);
    send(OP_CLOUD, 8'hFF, 64'd20, 2'd0, 32'hFFFFFFFF);
    send(OP_ODOM, 8'hFF, 64'd21, 2'd2, 32'h12345678);
    send(OP_CLOUD, 8'h05, 64'd20, 2'd0, 32'h1);
    send(OP_ODOM, 8'h05, 64'd15, 2'd1, 32'h2);
    send(OP_CLOUD, 8'h05, 64'd5000000, 2'd0, 32'h3);
    send(OP_CLEAR, 8'h00, 64'd0, 2'd0, 32'h0);
    send(OP_UNUSED, 8'hAA, 64'd1, 2'd1, 32'h5);
    send(OP_ODOM, 8'h05, 64'd5000001, 2'd1, 32'h4);
    send(OP_CLOUD, 8'h07, 64'hFFFFFFFFFFFFFFFE, 2'd0, 32'h6);
    send(OP_ODOM, 8'h07, 64'hFFFFFFFFFFFFFFFF, 2'd0, 32'h7);
    send(OP_CLEAR, 8'h00, 64'd0, 2'd0, 32'h0);
    for (int i = 0; i < 10; i++) send(OP_CLOUD, 8'(i), 64'(100 + i), 2'd0, 32'(i));
    send(OP_ODOM, 8'd9, 64'd200, 2'd0, 32'h9);

    write_reg(REG_SYNC, 32'd0);
    send(OP_CLOUD, 8'h11, 64'd3, 2'd0, 32'hAB);
    send(OP_ODOM, 8'h11, 64'd3, 2'd1, 32'hCD);
    write_reg(REG_SYNC, 32'd1);

    ts_base = 64'd1000;
    send(OP_CLEAR, 8'h00, 64'd0, 2'd0, 32'h0);
    random_run(250, 15);

    // long output hold-off while the sender keeps going
    hold_off = 1;
    random_run(60, 3);

    write_reg(REG_MAX_LAG, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    random_run(120, 3);
    write_reg(REG_MAX_LAG, 32'd31);
    write_reg(REG_TIMEOUT, 32'hFFFFFFFF);
    random_run(200, 31);
    write_reg(REG_MAX_LAG, 32'd16);
    write_reg(REG_TIMEOUT, 32'd250000);
    random_run(150, 7);
    write_reg(REG_SYNC, 32'd0);
    random_run(80, 255);
    write_reg(REG_SYNC, 32'd1);
    write_reg(REG_MAX_LAG, 32'd1);
    write_reg(REG_TIMEOUT, 32'd1000000);
    random_run(120, 2);
    write_reg(REG_MAX_LAG, 32'd8);
    calm = 1;
    random_run(130, 11);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== frame_id_pair_synchronizer.f =====
src/fisync_pkg.sv
src/fisync_front.sv
src/fisync_queue.sv
src/fisync_back.sv
src/frame_id_pair_synchronizer.sv
tb/frame_id_pair_synchronizer_chk.sv
tb/frame_id_pair_synchronizer_tb.sv
